FILE: hdl/dzv_pkg.sv
// Shared types and constants for the delta/zigzag varint encoder.
// No dependencies; imported by every module of the block.
package dzv_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned GroupWidth = 7;
  localparam int unsigned ByteWidth  = 8;
  localparam int unsigned XorWidth   = 32;

  // Mode register codes.
  localparam logic ModeDelta = 1'b0;
  localparam logic ModeXor   = 1'b1;

  // Input word: one column value.
  typedef struct packed {
    logic signed [ValueWidth-1:0] value_in;
    logic                         present;
    logic                         column_start;
  } in_word_t;

  // Output word: one varint byte.
  typedef struct packed {
    logic [ByteWidth-1:0] out_byte;
    logic                 last;
  } out_word_t;

  // Serializer status seen by the top level.
  typedef struct packed {
    logic load_ready;
    logic busy;
  } ser_status_t;

endpackage

FILE: hdl/dzv_code.sv
// Code generation: delta/zigzag or 32-bit XOR against the previous value.
// Holds the previous-value register. Depends on dzv_pkg.
module dzv_code
  import dzv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  in_word_t              item_i,
  input  logic                  take_i,
  input  logic                  mode_i,
  output logic [ValueWidth-1:0] code_o
);

  logic [ValueWidth-1:0] prev_q, prev_d;
  logic [ValueWidth-1:0] base;
  logic [ValueWidth-1:0] value;
  logic [ValueWidth-1:0] diff;
  logic [ValueWidth-1:0] zigzag;
  logic [ValueWidth-1:0] xor_code;

  // A column start clears the previous value before this word is coded.
  assign base  = item_i.column_start ? '0 : prev_q;
  assign value = item_i.value_in;

  // Delta then zigzag, or XOR of the low 32 bits.
  assign diff     = value - base;
  assign zigzag   = {diff[ValueWidth-2:0], 1'b0} ^ {ValueWidth{diff[ValueWidth-1]}};
  assign xor_code = {{(ValueWidth-XorWidth){1'b0}},
                     value[XorWidth-1:0] ^ base[XorWidth-1:0]};

  always_comb begin
    if (!item_i.present) begin
      code_o = '0;
    end else if (mode_i == ModeXor) begin
      code_o = xor_code;
    end else begin
      code_o = zigzag;
    end
  end

  // Previous value follows the word that leaves for the serializer.
  always_comb begin
    prev_d = base;
    if (item_i.present) begin
      if (mode_i == ModeXor) begin
        prev_d = {{(ValueWidth-XorWidth){1'b0}}, value[XorWidth-1:0]};
      end else begin
        prev_d = value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (take_i) begin
      prev_q <= prev_d;
    end
  end

endmodule

FILE: hdl/dzv_serializer.sv
// Varint serializer: shifts a code out seven bits per byte into an output register.
// Depends on dzv_pkg.
module dzv_serializer
  import dzv_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_valid_i,
  input  logic [ValueWidth-1:0] load_code_i,
  output ser_status_t           status_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_word_t             out_data_o
);

  logic                  ser_valid_q;
  logic [ValueWidth-1:0] code_q;
  logic                  out_valid_q;
  out_word_t             out_q;
  logic                  more;
  logic                  emit;
  logic                  load;

  // More bytes follow while any bit above the low group is set.
  assign more = |code_q[ValueWidth-1:GroupWidth];
  assign emit = ser_valid_q && (!out_valid_q || out_ready_i);
  assign status_o.load_ready = !ser_valid_q || (emit && !more);
  assign status_o.busy       = ser_valid_q;
  assign load = load_valid_i && status_o.load_ready;

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ser_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        ser_valid_q <= 1'b1;
      end else if (emit && !more) begin
        ser_valid_q <= 1'b0;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Code shift register and output byte register.
  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= load_code_i;
    end else if (emit) begin
      code_q <= code_q >> GroupWidth;
    end
    if (emit) begin
      out_q.out_byte <= {more, code_q[GroupWidth-1:0]};
      out_q.last     <= !more;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/delta_zigzag_varint_encoder_top.sv
// Top level of the delta/zigzag varint encoder.
// Depends on dzv_pkg, dzv_code and dzv_serializer.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one column value per
//   word. Output channel (out_valid_o/out_ready_i/out_data_o) gives the varint
//   bytes, low group first, with last set on the final byte of each word.
//   The configuration channel (cfg_valid_i/cfg_ready_o/cfg_data_i) writes the
//   mode bit: 0 for delta and zigzag, 1 for 32-bit XOR. It is always ready.
// Path: a word goes from the input register to the serializer shift register,
//   then to the output byte register, waiting its turn while either is busy.
// Throughput: one output byte per cycle while the receiver takes them; a word
//   has 1 to 10 bytes, shifted out of the serializer shift register. The
//   next word is coded and waits in the input register meanwhile.
// Reset clears the mode to delta, the previous value to zero, and empties the
//   pipeline. When the receiver stalls, the output byte holds, the serializer
//   stops, and the input register fills and then drops in_ready_o.
module delta_zigzag_varint_encoder_top
  import dzv_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i
);

  logic                  mode_q;
  logic                  in_valid_q;
  in_word_t              in_q;
  logic                  take;
  logic [ValueWidth-1:0] code;
  ser_status_t           ser_status;

  // Mode register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeDelta;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // Input register: refills in the cycle its word moves to the serializer.
  assign take       = in_valid_q && ser_status.load_ready;
  assign in_ready_o = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  dzv_code u_code (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (in_q),
    .take_i (take),
    .mode_i (mode_q),
    .code_o (code)
  );

  dzv_serializer u_ser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (in_valid_q),
    .load_code_i  (code),
    .status_o     (ser_status),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // The continuation bit of every byte is the inverse of its last flag.
  a_cont_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_byte[ByteWidth-1] == !out_data_o.last))
    else $error("continuation bit disagrees with last flag");

  // An empty input register always accepts.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input register empty but not ready");

  // A new output byte comes only from a busy serializer.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(ser_status.busy))
    else $error("output byte without serializer activity");

endmodule
